>>> design/ultrasonic_range_measurer_macros.svh
// ----------------------------------------------------------------------------
// Ultrasonic range measurer assertion macros
// Shared helpers for concurrent checks clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_MEASURER_MACROS_SVH
`define ULTRASONIC_RANGE_MEASURER_MACROS_SVH

// Same-cycle implication
`define URM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define URM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/urm_pkg.sv
// ----------------------------------------------------------------------------
// urm_pkg
// Types, constants and register codes of the ultrasonic range measurer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urm_pkg;

  // Echo counter width default
  localparam int unsigned CountBitsDef = 16;

  // Register widths
  localparam int unsigned SampleCountW = 8;
  localparam int unsigned TrigTicksW   = 4;
  localparam int unsigned HalfSpeedW   = 12;
  localparam int unsigned CfgDataW     = 12;
  localparam int unsigned CfgIdxW      = 2;

  // Register reset values; 1152 is half the speed of sound at 33.5 C in Q16
  localparam logic [SampleCountW-1:0] SampleCountRst = 8'd5;
  localparam logic [TrigTicksW-1:0]   TrigTicksRst   = 4'd10;
  localparam logic [HalfSpeedW-1:0]   HalfSpeedRst   = 12'd1152;

  // Distance format
  localparam int unsigned DistW      = 12;
  localparam int unsigned DistOutW   = 13;
  localparam int unsigned FracBits   = 16;
  localparam logic [DistW-1:0]    DistMax    = 12'd4095;
  localparam logic [DistOutW-1:0] DistNegOne = 13'h1FFF;

  // Register indexes on the config port
  typedef enum logic [CfgIdxW-1:0] {
    CfgSampleCount = 2'd0,
    CfgTrigTicks   = 2'd1,
    CfgHalfSpeed   = 2'd2
  } cfg_idx_e;

  // Measurement phase
  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhTrig = 2'd1,
    PhEcho = 2'd2
  } phase_e;

  // Operation codes
  typedef enum logic {
    OpTick  = 1'b0,
    OpStart = 1'b1
  } op_e;

  typedef struct packed {
    logic [SampleCountW-1:0] sample_count;
    logic [TrigTicksW-1:0]   trigger_ticks;
    logic [HalfSpeedW-1:0]   half_speed_q16;
  } cfg_t;

  typedef struct packed {
    op_e  operation;
    logic echo_level;
  } item_t;

  // Packed in tdata order, lowest field last
  typedef struct packed {
    logic signed [DistOutW-1:0] range_cm;
    logic                       done_res;
    logic                       busy_res;
    logic                       trigger_out;
  } result_t;

endpackage

>>> design/ultrasonic_range_measurer.sv
// ----------------------------------------------------------------------------
// Ultrasonic range measurer
// Echo-ranging sequencer for HC-SR04 style sensors, one transaction per tick.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the master side does not stall, and
// returns exactly one result for each. A transaction is either a microsecond
// tick carrying the sampled echo level or a start command. It passes the input
// register, then the result register; throughput is one transaction per cycle
// while the output is not stalled, set by the sequencer's state update. Distance
// is kept as a running sum of the half-speed coefficient, so no multiplier sits in
// the path. Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the
// user must do so only while no transaction is in flight; the block does not enforce it.
`timescale 1ns / 1ps

module ultrasonic_range_measurer #(
  parameter int unsigned COUNT_BITS = urm_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port
  input  logic                         cfg_we_i,
  input  logic [urm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [urm_pkg::CfgDataW-1:0] cfg_data_i,
  // Slave side
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [0] echo_level, [7:1] zero
  input  logic [0:0]                   s_axis_tuser,   // [0] operation
  // Master side
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata    // [0] trigger_out, [1] busy_res,
                                                       // [2] done_res, [15:3] range_cm
);

  urm_pkg::cfg_t    cfg;
  urm_pkg::item_t   in_item;
  urm_pkg::item_t   item;
  urm_pkg::result_t result;
  urm_pkg::result_t out_result;
  logic             item_valid;
  logic             advance;

  assign in_item.operation  = urm_pkg::op_e'(s_axis_tuser[0]);
  assign in_item.echo_level = s_axis_tdata[0];

  urm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  urm_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .item_valid_o (item_valid),
    .item_o       (item),
    .advance_i    (advance)
  );

  urm_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .item_i    (item),
    .result_o  (result)
  );

  urm_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .result_i     (result),
    .advance_o    (advance),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (out_result)
  );

  assign m_axis_tdata = out_result;

endmodule

>>> design/urm_cfg_regs.sv
// ----------------------------------------------------------------------------
// urm_cfg_regs
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [urm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [urm_pkg::CfgDataW-1:0]  cfg_data_i,
  output urm_pkg::cfg_t                 cfg_o
);

  urm_pkg::cfg_t cfg_q;

  // Register writes; unlisted indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_count   <= urm_pkg::SampleCountRst;
      cfg_q.trigger_ticks  <= urm_pkg::TrigTicksRst;
      cfg_q.half_speed_q16 <= urm_pkg::HalfSpeedRst;
    end else if (cfg_we_i) begin
      unique case (urm_pkg::cfg_idx_e'(cfg_idx_i))
        urm_pkg::CfgSampleCount: begin
          cfg_q.sample_count <= cfg_data_i[urm_pkg::SampleCountW-1:0];
        end
        urm_pkg::CfgTrigTicks: begin
          cfg_q.trigger_ticks <= cfg_data_i[urm_pkg::TrigTicksW-1:0];
        end
        urm_pkg::CfgHalfSpeed: begin
          cfg_q.half_speed_q16 <= cfg_data_i[urm_pkg::HalfSpeedW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/urm_in_stage.sv
// ----------------------------------------------------------------------------
// urm_in_stage
// Input register holding one accepted transaction until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urm_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  urm_pkg::item_t  in_item_i,
  output logic            item_valid_o,
  output urm_pkg::item_t  item_o,
  input  logic            advance_i
);

  logic           valid_q;
  urm_pkg::item_t item_q;

  // Free when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

>>> design/urm_core.sv
// ----------------------------------------------------------------------------
// urm_core
// Measurement sequencer: trigger pulse, echo count, distance and maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urm_core #(
  parameter int unsigned COUNT_BITS = urm_pkg::CountBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  urm_pkg::cfg_t    cfg_i,
  input  logic             advance_i,
  input  urm_pkg::item_t   item_i,
  output urm_pkg::result_t result_o
);

  // Running product of echo count and half speed
  localparam int unsigned AccW = COUNT_BITS + urm_pkg::HalfSpeedW;
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  urm_pkg::phase_e                   phase_q, phase_d;
  logic [urm_pkg::TrigTicksW-1:0]    pulse_q, pulse_d;
  logic [COUNT_BITS-1:0]             echo_cnt_q, echo_cnt_d;
  logic [AccW-1:0]                   acc_q, acc_d;
  logic [urm_pkg::SampleCountW-1:0]  samples_q, samples_d;
  logic [urm_pkg::DistW-1:0]         best_q, best_d;
  logic                              trig_q, trig_d;

  logic [urm_pkg::TrigTicksW-1:0]    pulse_lim;
  logic [urm_pkg::TrigTicksW-1:0]    pulse_inc;
  logic [urm_pkg::SampleCountW-1:0]  sample_lim;
  logic [urm_pkg::SampleCountW-1:0]  samples_inc;
  logic [AccW-1:0]                   acc_int;
  logic [urm_pkg::DistW-1:0]         dist_now;
  logic                              done;
  logic [urm_pkg::DistOutW-1:0]      dist_out;

  // Zero limits act as one
  assign pulse_lim  = (cfg_i.trigger_ticks == '0) ? urm_pkg::TrigTicksW'(1)
                                                  : cfg_i.trigger_ticks;
  assign sample_lim = (cfg_i.sample_count == '0) ? urm_pkg::SampleCountW'(1)
                                                 : cfg_i.sample_count;
  assign pulse_inc   = pulse_q + urm_pkg::TrigTicksW'(1);
  assign samples_inc = samples_q + urm_pkg::SampleCountW'(1);

  // Distance in cm: integer part of the Q16 product, saturated
  assign acc_int  = acc_q >> urm_pkg::FracBits;
  assign dist_now = (acc_int > AccW'(urm_pkg::DistMax)) ? urm_pkg::DistMax
                                                        : acc_int[urm_pkg::DistW-1:0];

  // Next state and result
  always_comb begin
    phase_d    = phase_q;
    pulse_d    = pulse_q;
    echo_cnt_d = echo_cnt_q;
    acc_d      = acc_q;
    samples_d  = samples_q;
    best_d     = best_q;
    trig_d     = trig_q;
    done       = 1'b0;
    dist_out   = '0;

    if (item_i.operation == urm_pkg::OpStart) begin
      if (phase_q != urm_pkg::PhTrig && phase_q != urm_pkg::PhEcho) begin
        phase_d    = urm_pkg::PhTrig;
        pulse_d    = '0;
        echo_cnt_d = '0;
        acc_d      = '0;
        samples_d  = '0;
        best_d     = '0;
        trig_d     = 1'b1;
      end
    end else begin
      unique case (phase_q)
        urm_pkg::PhTrig: begin
          pulse_d = pulse_inc;
          if (pulse_inc >= pulse_lim) begin
            trig_d     = 1'b0;
            phase_d    = urm_pkg::PhEcho;
            echo_cnt_d = '0;
            acc_d      = '0;
          end
        end
        urm_pkg::PhEcho: begin
          if (item_i.echo_level) begin
            if (echo_cnt_q != CountMax) begin
              echo_cnt_d = echo_cnt_q + COUNT_BITS'(1);
              acc_d      = acc_q + AccW'(cfg_i.half_speed_q16);
            end
          end else begin
            if (dist_now > best_q) begin
              best_d = dist_now;
            end
            samples_d = samples_inc;
            if (samples_inc >= sample_lim) begin
              phase_d  = urm_pkg::PhIdle;
              trig_d   = 1'b0;
              done     = 1'b1;
              dist_out = (best_d != '0) ? urm_pkg::DistOutW'(best_d)
                                        : urm_pkg::DistNegOne;
            end else begin
              phase_d = urm_pkg::PhTrig;
              pulse_d = '0;
              trig_d  = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers, updated once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= urm_pkg::PhIdle;
      pulse_q    <= '0;
      echo_cnt_q <= '0;
      acc_q      <= '0;
      samples_q  <= '0;
      best_q     <= '0;
      trig_q     <= 1'b0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      pulse_q    <= pulse_d;
      echo_cnt_q <= echo_cnt_d;
      acc_q      <= acc_d;
      samples_q  <= samples_d;
      best_q     <= best_d;
      trig_q     <= trig_d;
    end
  end

  assign result_o.trigger_out = trig_d;
  assign result_o.busy_res    = (phase_d == urm_pkg::PhTrig) || (phase_d == urm_pkg::PhEcho);
  assign result_o.done_res    = done;
  assign result_o.range_cm    = dist_out;

endmodule

>>> design/urm_out_stage.sv
// ----------------------------------------------------------------------------
// urm_out_stage
// Result register facing the master side of the stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urm_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  urm_pkg::result_t  result_i,
  output logic              advance_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output urm_pkg::result_t  out_result_o
);

  logic             valid_q;
  urm_pkg::result_t result_q;

  // Core result is taken when the register is empty or being drained
  assign advance_o = item_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

>>> design/urm_checker.sv
// ----------------------------------------------------------------------------
// urm_checker
// Port-level checks of the ultrasonic range measurer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ultrasonic_range_measurer_macros.svh"

module urm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Stalled result holds
  `URM_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Completion leaves the block idle with the trigger low
  `URM_ASSERT_IMP(a_done_idle, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[1] && !m_axis_tdata[0], "done while busy or triggering")

  // Distance is reported only on completion, and never as zero there
  `URM_ASSERT_IMP(a_dist_done, m_axis_tvalid, m_axis_tdata[2] == (m_axis_tdata[15:3] != 13'd0), "distance outside completion")

  // Trigger drive only during a sequence
  `URM_ASSERT_IMP(a_trig_busy, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[1], "trigger high while idle")

endmodule

bind ultrasonic_range_measurer urm_checker u_urm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/ultrasonic_range_measurer_test.sv
// ----------------------------------------------------------------------------
// Ultrasonic range measurer testbench
// Drives tick and start transactions with random gaps on both stream sides.
// A transaction-level predictor of the sequencer computes the result of each
// accepted transaction. The monitor checks every returned result, field by
// field, against the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_range_measurer_test;
  import urm_pkg::*;

  localparam int unsigned CountW     = CountBitsDef;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxPrints  = 50;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;  // [0] echo_level, [7:1] zero
  logic [0:0]          s_axis_tuser  = '0;  // [0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;        // [0] trigger_out, [1] busy_res,
                                            // [2] done_res, [15:3] range_cm

  ultrasonic_range_measurer #(
    .COUNT_BITS(CountW)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Transactions waiting to be sent, and results predicted but not yet seen
  item_t   sample_stream[$];
  result_t expected_reports[$];

  int unsigned pushed        = 0;
  int unsigned err_cnt       = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        in_taken      = 1'b0;
  logic        hold_go       = 1'b0;
  logic        recv_hold     = 1'b0;

  // Predictor copy of the sequencer state and the registers
  cfg_t                ranger_cfg  = '{SampleCountRst, TrigTicksRst, HalfSpeedRst};
  phase_e              rng_phase   = PhIdle;
  logic [3:0]          pulse_ticks = '0;
  logic [CountW-1:0]   echo_ticks  = '0;
  logic [7:0]          meas_done   = '0;
  logic [DistW-1:0]    best_cm     = '0;
  logic                trig_lvl    = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the predicted sequencer by one transaction, return its result
  function automatic result_t advance_ranger(item_t it);
    result_t                       r;
    logic                          busy;
    logic [3:0]                    lim;
    logic [7:0]                    need;
    logic [CountW+HalfSpeedW-1:0]  prod;
    logic [CountW+HalfSpeedW-1:0]  scaled;
    logic [DistW-1:0]              cm;
    r    = '0;
    busy = (rng_phase == PhTrig) || (rng_phase == PhEcho);
    if (it.operation == OpStart) begin
      // a start while busy changes nothing
      if (!busy) begin
        rng_phase   = PhTrig;
        pulse_ticks = '0;
        echo_ticks  = '0;
        meas_done   = '0;
        best_cm     = '0;
        trig_lvl    = 1'b1;
      end
    end else if (rng_phase == PhTrig) begin
      lim         = (ranger_cfg.trigger_ticks == 0) ? 4'd1 : ranger_cfg.trigger_ticks;
      pulse_ticks = pulse_ticks + 4'd1;
      if (pulse_ticks >= lim) begin
        trig_lvl   = 1'b0;
        rng_phase  = PhEcho;
        echo_ticks = '0;
      end
    end else if (rng_phase == PhEcho) begin
      if (it.echo_level) begin
        if (echo_ticks != '1) echo_ticks = echo_ticks + 1'b1;
      end else begin
        // echo fell: convert, keep the max, then next sample or finish
        prod   = echo_ticks * ranger_cfg.half_speed_q16;
        scaled = prod >> FracBits;
        cm     = (scaled > DistMax) ? DistMax : scaled[DistW-1:0];
        if (cm > best_cm) best_cm = cm;
        need      = (ranger_cfg.sample_count == 0) ? 8'd1 : ranger_cfg.sample_count;
        meas_done = meas_done + 8'd1;
        if (meas_done >= need) begin
          rng_phase     = PhIdle;
          trig_lvl      = 1'b0;
          r.done_res    = 1'b1;
          r.range_cm    = (best_cm != 0) ? {1'b0, best_cm} : DistNegOne;
        end else begin
          rng_phase   = PhTrig;
          pulse_ticks = '0;
          trig_lvl    = 1'b1;
        end
      end
    end
    r.trigger_out = trig_lvl;
    r.busy_res    = (rng_phase == PhTrig) || (rng_phase == PhEcho);
    return r;
  endfunction

  task automatic flag_field(string field, int got, int want);
    if (err_cnt < MaxPrints) begin
      $display("mismatch at %0t ns: %s got %0d expected %0d", $time, field, got, want);
    end
    err_cnt++;
  endtask

  // Register shadow, prediction on input transactions, result checks
  always @(posedge clk_i) begin : check_blk
    item_t   it;
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgSampleCount: ranger_cfg.sample_count   = cfg_data_i[SampleCountW-1:0];
          CfgTrigTicks:   ranger_cfg.trigger_ticks  = cfg_data_i[TrigTicksW-1:0];
          CfgHalfSpeed:   ranger_cfg.half_speed_q16 = cfg_data_i[HalfSpeedW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.operation  = op_e'(s_axis_tuser[0]);
        it.echo_level = s_axis_tdata[0];
        expected_reports.insert(expected_reports.size(), advance_ranger(it));
        in_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        if (expected_reports.size() == 0) begin
          flag_field("result with nothing pending, tdata", int'(m_axis_tdata), 0);
        end else begin
          want = expected_reports.pop_front();
          if (got.trigger_out != want.trigger_out)
            flag_field("trigger_out", got.trigger_out, want.trigger_out);
          if (got.busy_res != want.busy_res)
            flag_field("busy_res", got.busy_res, want.busy_res);
          if (got.done_res != want.done_res)
            flag_field("done_res", got.done_res, want.done_res);
          if (got.range_cm != want.range_cm)
            flag_field("range_cm", int'(got.range_cm), int'(want.range_cm));
        end
      end
    end
  end

  // Sender and receiver, both updated on the falling edge
  always @(negedge clk_i) begin : drive_blk
    item_t nxt;
    if (!s_axis_tvalid || in_taken) begin
      if (sample_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = sample_stream.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'b0, nxt.echo_level};
        s_axis_tuser  <= nxt.operation;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    m_axis_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Long receiver hold-off so the block backs up into its input
  initial begin : hold_off_blk
    wait (hold_go);
    @(posedge clk_i);
    recv_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    recv_hold = 1'b0;
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAIL ultrasonic_range_measurer");
      $finish;
    end
  end

  function automatic void push_item(op_e op, logic echo);
    item_t it;
    it.operation  = op;
    it.echo_level = echo;
    sample_stream.insert(sample_stream.size(), it);
    pushed++;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Wait for every result, then flush any open sequence with echo-low ticks
  task automatic settle();
    forever begin
      @(posedge clk_i);
      if (sample_stream.size() == 0 && !s_axis_tvalid && expected_reports.size() == 0) begin
        if (rng_phase == PhIdle) break;
        repeat (64) push_item(OpTick, 1'b0);
      end
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_config();
    logic [7:0]  sc;
    logic [3:0]  tt;
    logic [11:0] hs;
    case ($urandom_range(0, 7))
      0:       sc = 8'd0;
      1:       sc = 8'd1;
      default: sc = 8'($urandom_range(2, 3));
    endcase
    case ($urandom_range(0, 9))
      0:       tt = 4'd0;
      1:       tt = 4'd15;
      2:       tt = 4'd1;
      default: tt = 4'($urandom_range(1, 15));
    endcase
    case ($urandom_range(0, 9))
      0:       hs = 12'd0;
      1:       hs = 12'd4095;
      2:       hs = 12'($urandom_range(1, 4095));
      default: hs = 12'($urandom_range(1024, 4095));
    endcase
    write_reg(CfgSampleCount, CfgDataW'(sc));
    write_reg(CfgTrigTicks,   CfgDataW'(tt));
    write_reg(CfgHalfSpeed,   CfgDataW'(hs));
  endtask

  // Mostly complete measurement sequences with random echo lengths,
  // sprinkled with stray transactions and starts during a sequence
  task automatic gen_group(int unsigned target);
    int unsigned first;
    int unsigned n_eff;
    int unsigned t_eff;
    int unsigned run_len;
    first = pushed;
    while (pushed - first < target) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(op_e'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        n_eff = (ranger_cfg.sample_count == 0) ? 1 : ranger_cfg.sample_count;
        t_eff = (ranger_cfg.trigger_ticks == 0) ? 1 : ranger_cfg.trigger_ticks;
        push_item(OpStart, 1'($urandom_range(0, 1)));
        repeat (n_eff) begin
          repeat (t_eff) push_item(OpTick, 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 19) == 0) push_item(OpStart, 1'($urandom_range(0, 1)));
          run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(0, 24);
          repeat (run_len) push_item(OpTick, 1'b1);
          push_item(OpTick, 1'b0);
        end
      end
    end
  endtask

  task automatic run_mode(int unsigned snd, int unsigned rcv, bit with_hold);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    for (int g = 0; g < 2; g++) begin
      random_config();
      gen_group(20);
      if (with_hold && g == 0) hold_go = 1'b1;
      settle();
    end
  endtask

  initial begin : stimulus
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle_pct = 14;
    recv_idle_pct = 65;

    // Directed: idle ticks, start while busy, one-tick trigger, zero distance
    write_reg(CfgSampleCount, 12'd2);
    write_reg(CfgTrigTicks,   12'd1);
    write_reg(CfgHalfSpeed,   12'd4095);
    push_item(OpTick, 1'b1);
    push_item(OpTick, 1'b0);
    push_item(OpStart, 1'b0);
    push_item(OpStart, 1'b1);
    push_item(OpTick, 1'b1);
    repeat (2) push_item(OpTick, 1'b1);
    push_item(OpTick, 1'b0);
    push_item(OpTick, 1'b0);
    push_item(OpTick, 1'b0);
    settle();

    // Directed: zero sample count and zero trigger length act as one,
    // seventeen echo ticks give the first whole centimetre
    write_reg(CfgSampleCount, 12'd0);
    write_reg(CfgTrigTicks,   12'd0);
    push_item(OpStart, 1'b1);
    push_item(OpTick, 1'b0);
    repeat (17) push_item(OpTick, 1'b1);
    push_item(OpTick, 1'b0);
    settle();

    run_mode(14, 65, 1'b1);
    run_mode(65, 14, 1'b0);
    run_mode(0, 0, 1'b0);

    // Largest sample count, mostly empty echoes
    write_reg(CfgSampleCount, 12'd255);
    write_reg(CfgTrigTicks,   12'd1);
    write_reg(CfgHalfSpeed,   12'($urandom_range(0, 4095)));
    push_item(OpStart, 1'b0);
    repeat (255) begin
      push_item(OpTick, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 31) == 0) repeat ($urandom_range(1, 30)) push_item(OpTick, 1'b1);
      push_item(OpTick, 1'b0);
    end
    settle();

    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS ultrasonic_range_measurer");
    end else begin
      $display("FAIL ultrasonic_range_measurer");
    end
    $finish;
  end

endmodule
